### design/jpd_pkg.sv
// Shared types and constants for the jump phase detector.
// No dependencies; imported by every module of the block.
package jpd_pkg;

   localparam int NOW_W      = 32;
   localparam int ALT_W      = 17;
   localparam int RATE_W     = 21;
   localparam int HOLD_W     = 33;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;
   localparam int DIVIDEND_W = 33;
   localparam int DIVISOR_W  = 32;
   localparam int DIV_CNT_W  = $clog2(DIVIDEND_W + 1);

   localparam logic [15:0] MS_PER_MIN = 16'd60000;

   localparam logic signed [RATE_W-1:0] RATE_MAX = 21'sd1048575;
   localparam logic signed [RATE_W-1:0] RATE_MIN = -21'sd1048576;

   // register indexes on the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_CLIMB_THRESHOLD = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_JUMP_THRESHOLD  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LANDED_BAND     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LANDED_HOLD     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_RATE_PERIOD     = 3'd4;

   // phase codes as seen on the result channel
   localparam logic [1:0] PHASE_WAIT    = 2'd0;
   localparam logic [1:0] PHASE_FLIGHT  = 2'd1;
   localparam logic [1:0] PHASE_JUMPING = 2'd2;
   localparam logic [1:0] PHASE_LANDED  = 2'd3;

   // sequencer strobes into the phase unit
   typedef struct packed {
      logic hold_step;
      logic phase_step;
   } phase_ctrl_type;

   // divider status back to the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

### design/jpd_divider.sv
// Iterative restoring divider, one quotient bit per cycle.
// Depends on jpd_pkg for widths and the status struct.
module jpd_divider (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [jpd_pkg::DIVIDEND_W-1:0]   dividend,
   input  logic [jpd_pkg::DIVISOR_W-1:0]    divisor,
   output logic [jpd_pkg::DIVIDEND_W-1:0]   quotient,
   output jpd_pkg::div_status_type          status
);
   import jpd_pkg::*;

   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  divisor_ff, divisor_in;
   logic [DIV_CNT_W-1:0]  count_ff, count_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [DIVISOR_W:0]    trial;
   logic [DIVISOR_W:0]    diff;
   logic                  fits;

   assign trial = {rem_ff, quo_ff[DIVIDEND_W-1]};
   assign diff  = trial - {1'b0, divisor_ff};
   assign fits  = ~diff[DIVISOR_W];

   always_comb begin
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      divisor_in = divisor_ff;
      count_in   = count_ff;
      busy_in    = busy_ff;
      done_in    = 1'b0;
      if (start) begin
         rem_in     = '0;
         quo_in     = dividend;
         divisor_in = divisor;
         count_in   = DIV_CNT_W'(DIVIDEND_W);
         busy_in    = 1'b1;
      end else if (busy_ff) begin
         rem_in   = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
         quo_in   = {quo_ff[DIVIDEND_W-2:0], fits};
         count_in = count_ff - 1'b1;
         if (count_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      divisor_ff <= divisor_in;
   end

   assign quotient    = quo_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("divider started while busy");
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> rem_ff < divisor_ff)
      else $error("partial remainder not below divisor");
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff))
      else $error("divider done without a running division");

endmodule

### design/jpd_phase.sv
// Phase state machine with the landed hold timer.
// Depends on jpd_pkg; stepped by the sequencer in the top level.
module jpd_phase (
   input  logic                                 clock,
   input  logic                                 reset,
   input  jpd_pkg::phase_ctrl_type              ctrl,
   input  logic [jpd_pkg::NOW_W-1:0]            now_ms,
   input  logic signed [jpd_pkg::RATE_W-1:0]    climb_rate,
   input  logic [15:0]                          climb_threshold_fpm,
   input  logic signed [16:0]                   jump_threshold_fpm,
   input  logic [15:0]                          landed_band_fpm,
   input  logic [23:0]                          landed_hold_ms,
   output logic [1:0]                           phase,
   output logic                                 phase_changed
);
   import jpd_pkg::*;

   typedef enum logic [3:0] {
      PH_WAIT    = 4'b0001,
      PH_FLIGHT  = 4'b0010,
      PH_JUMPING = 4'b0100,
      PH_LANDED  = 4'b1000
   } phase_state_type;

   phase_state_type          phase_ff, phase_in;
   logic                     changed_ff, changed_in;
   logic [NOW_W-1:0]         last_loop_ff, last_loop_in;
   logic signed [HOLD_W-1:0] hold_ff, hold_in;
   logic                     active_ff, active_in;

   logic [NOW_W-1:0]         delta;
   logic [HOLD_W:0]          hold_diff;
   logic signed [RATE_W:0]   rate_x;
   logic signed [RATE_W:0]   mag_x;
   logic signed [RATE_W:0]   climb_x;
   logic signed [RATE_W:0]   jump_x;
   logic signed [RATE_W:0]   band_x;
   logic                     hold_expired;

   assign delta     = now_ms - last_loop_ff;
   assign hold_diff = {hold_ff[HOLD_W-1], hold_ff} - {2'b00, delta};
   assign rate_x    = {climb_rate[RATE_W-1], climb_rate};
   assign mag_x     = rate_x[RATE_W] ? -rate_x : rate_x;
   assign climb_x   = {6'b0, climb_threshold_fpm};
   assign jump_x    = {{5{jump_threshold_fpm[16]}}, jump_threshold_fpm};
   assign band_x    = {6'b0, landed_band_fpm};
   assign hold_expired = active_ff && (hold_ff[HOLD_W-1] || hold_ff == '0);

   always_comb begin
      phase_in     = phase_ff;
      changed_in   = changed_ff;
      last_loop_in = last_loop_ff;
      hold_in      = hold_ff;
      active_in    = active_ff;
      if (ctrl.hold_step && delta != '0) begin
         last_loop_in = now_ms;
         if (active_ff) begin
            // clamp at the most negative hold value
            if (hold_diff[HOLD_W:HOLD_W-1] == 2'b10) begin
               hold_in = {1'b1, {(HOLD_W-1){1'b0}}};
            end else begin
               hold_in = hold_diff[HOLD_W-1:0];
            end
         end
      end
      if (ctrl.phase_step) begin
         unique case (phase_ff)
            PH_WAIT: begin
               if (rate_x > climb_x) phase_in = PH_FLIGHT;
            end
            PH_FLIGHT: begin
               if (rate_x <= jump_x) phase_in = PH_JUMPING;
            end
            PH_JUMPING: begin
               if (mag_x <= band_x) begin
                  phase_in  = PH_LANDED;
                  hold_in   = {9'b0, landed_hold_ms};
                  active_in = 1'b1;
               end
            end
            PH_LANDED: begin
               priority if (rate_x <= jump_x) begin
                  phase_in  = PH_JUMPING;
                  active_in = 1'b0;
               end else if (mag_x >= climb_x) begin
                  phase_in  = PH_FLIGHT;
                  active_in = 1'b0;
               end else if (hold_expired) begin
                  phase_in  = PH_WAIT;
                  active_in = 1'b0;
               end
            end
            default: phase_in = PH_WAIT;
         endcase
         changed_in = (phase_in != phase_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_WAIT;
         changed_ff   <= 1'b0;
         last_loop_ff <= '0;
         hold_ff      <= '0;
         active_ff    <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         changed_ff   <= changed_in;
         last_loop_ff <= last_loop_in;
         hold_ff      <= hold_in;
         active_ff    <= active_in;
      end
   end

   always_comb begin
      unique case (phase_ff)
         PH_WAIT:    phase = PHASE_WAIT;
         PH_FLIGHT:  phase = PHASE_FLIGHT;
         PH_JUMPING: phase = PHASE_JUMPING;
         PH_LANDED:  phase = PHASE_LANDED;
         default:    phase = PHASE_WAIT;
      endcase
   end

   assign phase_changed = changed_ff;

   a_hold_in_landed: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> phase_ff == PH_LANDED)
      else $error("hold timer running outside landed phase");
   a_steps_apart: assert property (@(posedge clock) disable iff (reset)
      !(ctrl.hold_step && ctrl.phase_step))
      else $error("hold and phase steps in the same cycle");
   a_phase_moves_on_step: assert property (@(posedge clock) disable iff (reset)
      !$stable(phase_ff) && $past(!reset) |-> $past(ctrl.phase_step))
      else $error("phase changed without a phase step");

endmodule

### design/jump_phase_detector.sv
// Jump phase detector top level: sequencer, rate registers, output stage.
// Depends on jpd_pkg, jpd_phase and jpd_divider.
//
// Usage: one transfer on the req_ channel is one loop pass (time in ms and
// altitude in feet). Each pass yields exactly one transfer on the rsp_
// channel with the phase, a phase-change flag, the climb rate and a flag
// for a rate update. The block takes one pass at a time; req_stall is low
// only while the sequencer is idle.
// Each pass runs the hold, phase and done steps; one that divides for a new
// rate also runs the multiply step and the serial divider (one quotient bit
// per cycle over 33 bits). A new pass can be taken on the cycle after the result is
// loaded into the output register, while that result still waits.
// If rsp_stall is held, the result stays in the output register and the
// following pass finishes and waits in its last step until that register
// is free. Reset (synchronous, active high) clears the phase to wait, the
// rate to zero, the timers, and loads the register defaults. csr_ writes
// are always ready and are meant to be made only while the block is idle.
module jump_phase_detector (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [31:0]                         req_now_ms,
   input  logic signed [16:0]                  req_altitude_ft,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [1:0]                          rsp_phase,
   output logic                                rsp_phase_changed,
   output logic signed [20:0]                  rsp_climb_rate_fpm,
   output logic                                rsp_rate_updated,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [jpd_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [jpd_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import jpd_pkg::*;

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_HOLD   = 7'b0000010,
      ST_PHASE  = 7'b0000100,
      ST_MUL    = 7'b0001000,
      ST_DSTART = 7'b0010000,
      ST_DIV    = 7'b0100000,
      ST_DONE   = 7'b1000000
   } seq_state_type;

   seq_state_type state_ff, state_in;

   // configuration
   logic [15:0]        climb_thr_ff;
   logic signed [16:0] jump_thr_ff;
   logic [15:0]        band_ff;
   logic [23:0]        hold_ms_ff;
   logic [15:0]        period_ff;

   // per pass working registers
   logic [NOW_W-1:0]          now_ff, now_in;
   logic signed [ALT_W-1:0]   alt_ff, alt_in;
   logic [NOW_W-1:0]          interval_ff, interval_in;
   logic signed [ALT_W:0]     diff_ff, diff_in;
   logic [DIVIDEND_W-1:0]     prod_ff, prod_in;
   logic                      neg_ff, neg_in;
   logic                      updated_ff, updated_in;

   // architectural rate state
   logic signed [RATE_W-1:0]  climb_rate_ff, climb_rate_in;
   logic signed [ALT_W-1:0]   prev_alt_ff, prev_alt_in;
   logic [NOW_W-1:0]          last_rate_ff, last_rate_in;
   logic                      first_sample_ff, first_sample_in;

   // output stage
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [1:0]                rsp_phase_ff, rsp_phase_in;
   logic                      rsp_changed_ff, rsp_changed_in;
   logic signed [RATE_W-1:0]  rsp_rate_ff, rsp_rate_in;
   logic                      rsp_updated_ff, rsp_updated_in;

   phase_ctrl_type            phase_ctrl;
   logic [1:0]                cur_phase;
   logic                      cur_changed;
   div_status_type            div_stat;
   logic [DIVIDEND_W-1:0]     quotient;
   logic                      div_start;
   logic                      take_req;
   logic                      out_free;
   logic                      rate_due;
   logic [ALT_W-1:0]          diff_mag;
   logic [DIVIDEND_W-1:0]     product;
   logic signed [RATE_W-1:0]  sat_rate;

   assign take_req  = req_valid && (state_ff == ST_IDLE);
   assign req_stall = (state_ff != ST_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = 1'b1;
   assign div_start = (state_ff == ST_DSTART);

   assign phase_ctrl.hold_step  = (state_ff == ST_HOLD);
   assign phase_ctrl.phase_step = (state_ff == ST_PHASE);

   assign rate_due = $signed({interval_ff[NOW_W-1], interval_ff})
                     > $signed({17'b0, period_ff});
   assign diff_mag = diff_ff[ALT_W] ? ALT_W'(-diff_ff) : diff_ff[ALT_W-1:0];
   assign product  = DIVIDEND_W'(diff_mag) * DIVIDEND_W'(MS_PER_MIN);

   // truncated quotient magnitude, signed and clamped
   always_comb begin
      if (neg_ff) begin
         if (quotient > DIVIDEND_W'(1048576)) begin
            sat_rate = RATE_MIN;
         end else begin
            sat_rate = RATE_W'(-quotient);
         end
      end else begin
         if (quotient > DIVIDEND_W'(1048575)) begin
            sat_rate = RATE_MAX;
         end else begin
            sat_rate = quotient[RATE_W-1:0];
         end
      end
   end

   always_comb begin
      state_in        = state_ff;
      now_in          = now_ff;
      alt_in          = alt_ff;
      interval_in     = interval_ff;
      diff_in         = diff_ff;
      prod_in         = prod_ff;
      neg_in          = neg_ff;
      updated_in      = updated_ff;
      climb_rate_in   = climb_rate_ff;
      prev_alt_in     = prev_alt_ff;
      last_rate_in    = last_rate_ff;
      first_sample_in = first_sample_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_phase_in    = rsp_phase_ff;
      rsp_changed_in  = rsp_changed_ff;
      rsp_rate_in     = rsp_rate_ff;
      rsp_updated_in  = rsp_updated_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (take_req) begin
               now_in   = req_now_ms;
               alt_in   = req_altitude_ft;
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            interval_in = now_ff - last_rate_ff;
            diff_in     = {alt_ff[ALT_W-1], alt_ff} - {prev_alt_ff[ALT_W-1], prev_alt_ff};
            state_in    = ST_PHASE;
         end
         ST_PHASE: begin
            updated_in = rate_due;
            neg_in     = diff_ff[ALT_W];
            if (!rate_due) begin
               state_in = ST_DONE;
            end else begin
               prev_alt_in  = alt_ff;
               last_rate_in = now_ff;
               if (first_sample_ff) begin
                  first_sample_in = 1'b0;
                  climb_rate_in   = '0;
                  state_in        = ST_DONE;
               end else begin
                  state_in = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            prod_in  = product;
            state_in = ST_DSTART;
         end
         ST_DSTART: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_stat.done) begin
               climb_rate_in = sat_rate;
               state_in      = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_phase_in   = cur_phase;
               rsp_changed_in = cur_changed;
               rsp_rate_in    = climb_rate_ff;
               rsp_updated_in = updated_ff;
               state_in       = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         climb_rate_ff   <= '0;
         prev_alt_ff     <= '0;
         last_rate_ff    <= '0;
         first_sample_ff <= 1'b1;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         climb_rate_ff   <= climb_rate_in;
         prev_alt_ff     <= prev_alt_in;
         last_rate_ff    <= last_rate_in;
         first_sample_ff <= first_sample_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      now_ff         <= now_in;
      alt_ff         <= alt_in;
      interval_ff    <= interval_in;
      diff_ff        <= diff_in;
      prod_ff        <= prod_in;
      neg_ff         <= neg_in;
      updated_ff     <= updated_in;
      rsp_phase_ff   <= rsp_phase_in;
      rsp_changed_ff <= rsp_changed_in;
      rsp_rate_ff    <= rsp_rate_in;
      rsp_updated_ff <= rsp_updated_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         climb_thr_ff <= 16'd300;
         jump_thr_ff  <= -17'sd5000;
         band_ff      <= 16'd100;
         hold_ms_ff   <= 24'd60000;
         period_ff    <= 16'd10000;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_CLIMB_THRESHOLD: climb_thr_ff <= csr_wdata[15:0];
            CSR_JUMP_THRESHOLD:  jump_thr_ff  <= csr_wdata[16:0];
            CSR_LANDED_BAND:     band_ff      <= csr_wdata[15:0];
            CSR_LANDED_HOLD:     hold_ms_ff   <= csr_wdata[23:0];
            CSR_RATE_PERIOD:     period_ff    <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   jpd_phase u_phase (
      .clock               (clock),
      .reset               (reset),
      .ctrl                (phase_ctrl),
      .now_ms              (now_ff),
      .climb_rate          (climb_rate_ff),
      .climb_threshold_fpm (climb_thr_ff),
      .jump_threshold_fpm  (jump_thr_ff),
      .landed_band_fpm     (band_ff),
      .landed_hold_ms      (hold_ms_ff),
      .phase               (cur_phase),
      .phase_changed       (cur_changed)
   );

   jpd_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod_ff),
      .divisor  (interval_ff),
      .quotient (quotient),
      .status   (div_stat)
   );

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_phase          = rsp_phase_ff;
   assign rsp_phase_changed  = rsp_changed_ff;
   assign rsp_climb_rate_fpm = rsp_rate_ff;
   assign rsp_rate_updated   = rsp_updated_ff;

   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      (div_stat.done || div_stat.busy) |-> state_ff == ST_DIV)
      else $error("divider active outside the divide step");
   a_rate_write: assert property (@(posedge clock) disable iff (reset)
      !$stable(climb_rate_ff) && $past(!reset)
      |-> $past(state_ff == ST_PHASE) || $past(state_ff == ST_DIV))
      else $error("climb rate changed outside its update steps");
   a_first_sample: assert property (@(posedge clock) disable iff (reset)
      $fell(first_sample_ff) |-> $past(state_ff == ST_PHASE))
      else $error("first sample flag cleared outside the phase step");

endmodule

### verif/tb.sv
// Self-checking bench for jump_phase_detector: a directed table, then random flight profiles
// under several register settings and idling patterns; unpinned passes use an in-bench predictor.
// Depends on jpd_pkg and the jump_phase_detector design only.
module tb;
   import jpd_pkg::*;

   typedef struct packed {
      logic [1:0]         phase;
      logic               changed;
      logic signed [20:0] rate;
      logic               updated;
   } pass_result_type;

   typedef struct packed {
      logic [31:0]        now;
      logic signed [16:0] alt;
      logic               pinned;
      pass_result_type    want;
   } script_row_type;

   typedef enum logic [1:0] {SEG_CLIMB, SEG_FREEFALL, SEG_GROUND, SEG_NOISE} flight_seg_type;

   localparam longint RATE_SCALE = 60000;
   localparam longint RATE_HI    = 1048575;
   localparam longint RATE_LO    = -1048576;
   localparam longint HOLD_FLOOR = -64'sd4294967296;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic [31:0]            req_now_ms;
   logic signed [16:0]     req_altitude_ft;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic [1:0]             rsp_phase;
   logic                   rsp_phase_changed;
   logic signed [20:0]     rsp_climb_rate_fpm;
   logic                   rsp_rate_updated;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   // predictor registers and state
   longint      climb_thr, jump_thr, band_fpm, hold_ms, period_ms;
   logic [1:0]  phase_q;
   int          climb_q;
   int          prev_alt;
   logic [31:0] last_rate_ms, last_loop_ms;
   logic        first_sample;
   longint      hold_left_ms;
   logic        hold_armed;

   pass_result_type expected_passes[$];
   pass_result_type pin_result;
   logic            pin_next;
   int              errors;
   int              idle_pct;
   int              stall_pct;
   int              hold_off_req;

   logic [31:0]     sim_now;
   int              sim_alt;
   flight_seg_type  seg_kind;
   int              seg_left;

   script_row_type  script [25];

   jump_phase_detector dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_now_ms         (req_now_ms),
      .req_altitude_ft    (req_altitude_ft),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_phase          (rsp_phase),
      .rsp_phase_changed  (rsp_phase_changed),
      .rsp_climb_rate_fpm (rsp_climb_rate_fpm),
      .rsp_rate_updated   (rsp_rate_updated),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic pass_result_type predict_pass(logic [31:0] now, logic signed [16:0] alt);
      logic [31:0]        dt;
      logic signed [31:0] span;
      longint             delta, rate, mag, interval, q, diff;
      int                 alt_i;
      logic [1:0]         old_phase;
      pass_result_type    r;
      dt = now - last_loop_ms;
      span = now - last_rate_ms;
      delta = dt;
      interval = span;
      alt_i = alt;
      old_phase = phase_q;
      rate = climb_q;
      mag = (rate < 0) ? -rate : rate;
      r.updated = 1'b0;
      if (delta != 0) begin
         if (hold_armed) begin
            hold_left_ms -= delta;
            if (hold_left_ms < HOLD_FLOOR) hold_left_ms = HOLD_FLOOR;
         end
         last_loop_ms = now;
      end
      case (phase_q)
         PHASE_WAIT: begin
            if (rate > climb_thr) phase_q = PHASE_FLIGHT;
         end
         PHASE_FLIGHT: begin
            if (rate <= jump_thr) phase_q = PHASE_JUMPING;
         end
         PHASE_JUMPING: begin
            if (mag <= band_fpm) begin
               phase_q = PHASE_LANDED;
               hold_left_ms = hold_ms;
               hold_armed = 1'b1;
            end
         end
         default: begin
            // jump threshold wins over climb, climb over the hold timer
            if (rate <= jump_thr) begin
               phase_q = PHASE_JUMPING;
               hold_armed = 1'b0;
            end else if (mag >= climb_thr) begin
               phase_q = PHASE_FLIGHT;
               hold_armed = 1'b0;
            end else if (hold_armed && hold_left_ms <= 0) begin
               phase_q = PHASE_WAIT;
               hold_armed = 1'b0;
            end
         end
      endcase
      if (interval > period_ms) begin
         if (first_sample) begin
            first_sample = 1'b0;
            climb_q = 0;
         end else begin
            diff = alt_i - prev_alt;
            q = diff * RATE_SCALE / interval;
            if (q > RATE_HI) q = RATE_HI;
            if (q < RATE_LO) q = RATE_LO;
            climb_q = int'(q);
         end
         prev_alt = alt_i;
         last_rate_ms = now;
         r.updated = 1'b1;
      end
      r.phase = phase_q;
      r.changed = (phase_q != old_phase);
      r.rate = climb_q[20:0];
      return r;
   endfunction

   always @(posedge clock) begin
      pass_result_type p;
      if (!reset && req_valid === 1'b1 && req_stall === 1'b0) begin
         p = predict_pass(req_now_ms, req_altitude_ft);
         expected_passes.push_back(pin_next ? pin_result : p);
      end
   end

   always @(posedge clock) begin
      pass_result_type e;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (expected_passes.size() == 0) begin
            $error("unexpected result transfer: phase %0d rate %0d", rsp_phase,
                   rsp_climb_rate_fpm);
            errors++;
         end else begin
            e = expected_passes.pop_front();
            if (rsp_phase !== e.phase) begin
               $error("phase: expected %0d, actual %0d", e.phase, rsp_phase);
               errors++;
            end
            if (rsp_phase_changed !== e.changed) begin
               $error("phase_changed: expected %0d, actual %0d", e.changed, rsp_phase_changed);
               errors++;
            end
            if (rsp_climb_rate_fpm !== e.rate) begin
               $error("climb_rate_fpm: expected %0d, actual %0d", e.rate, rsp_climb_rate_fpm);
               errors++;
            end
            if (rsp_rate_updated !== e.updated) begin
               $error("rate_updated: expected %0d, actual %0d", e.updated, rsp_rate_updated);
               errors++;
            end
         end
      end
   end

   // receiver: random stall, plus a long hold-off on request
   initial begin
      int hold_left;
      rsp_stall = 1'b0;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_off_req != 0) begin
            hold_left = hold_off_req;
            hold_off_req = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < stall_pct);
         end
      end
   end

   initial begin
      #5000000;
      $display("tb: FAIL");
      $finish;
   end

   task automatic offer_pass(input logic [31:0] now, input logic signed [16:0] alt,
                             input logic pin, input pass_result_type res);
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_now_ms <= now;
      req_altitude_ft <= alt;
      pin_next = pin;
      pin_result = res;
      do @(posedge clock); while (!(req_valid === 1'b1 && req_stall === 1'b0));
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (csr_ready !== 1'b1);
      case (idx)
         CSR_CLIMB_THRESHOLD: climb_thr = data[15:0];
         CSR_JUMP_THRESHOLD:  jump_thr = $signed(data[16:0]);
         CSR_LANDED_BAND:     band_fpm = data[15:0];
         CSR_LANDED_HOLD:     hold_ms = data[23:0];
         CSR_RATE_PERIOD:     period_ms = data[15:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic settle;
      while (expected_passes.size() != 0) @(posedge clock);
      repeat (5) @(posedge clock);
   endtask

   task automatic configure(input logic [23:0] climb, input logic [23:0] jump,
                            input logic [23:0] band, input logic [23:0] hold,
                            input logic [23:0] period, input int idle, input int stall);
      settle();
      idle_pct = idle;
      stall_pct = stall;
      write_reg(CSR_CLIMB_THRESHOLD, climb);
      write_reg(CSR_JUMP_THRESHOLD, jump);
      write_reg(CSR_LANDED_BAND, band);
      write_reg(CSR_LANDED_HOLD, hold);
      write_reg(CSR_RATE_PERIOD, period);
   endtask

   // climb, freefall and ground segments in turn, with the odd noisy stretch
   task automatic next_sample(output logic [31:0] now, output logic signed [16:0] alt);
      int unsigned pick;
      int          d;
      if (seg_left == 0) begin
         seg_left = $urandom_range(12, 3);
         if ($urandom_range(99) < 15) begin
            seg_kind = SEG_NOISE;
         end else begin
            case (seg_kind)
               SEG_CLIMB:    seg_kind = SEG_FREEFALL;
               SEG_FREEFALL: seg_kind = SEG_GROUND;
               default:      seg_kind = SEG_CLIMB;
            endcase
         end
      end
      seg_left--;
      pick = $urandom_range(99);
      if (seg_kind == SEG_NOISE && pick < 40) sim_now = $urandom();
      else if (pick < 65)
         sim_now += 32'(period_ms + 1 + $urandom_range(32'(period_ms / 8)));
      else if (pick < 85) sim_now += $urandom_range(32'(period_ms));
      else if (seg_kind == SEG_GROUND) sim_now += 32'(hold_ms + $urandom_range(2000));
      else sim_now += $urandom_range(300000);
      case (seg_kind)
         SEG_CLIMB:    d = $urandom_range(3000, 20);
         SEG_FREEFALL: d = -int'($urandom_range(8000, 200));
         SEG_GROUND:   d = int'($urandom_range(4)) - 2;
         default:      d = int'($urandom_range(73727)) - 8192 - sim_alt;
      endcase
      sim_alt += d;
      if (sim_alt > 65535) sim_alt = 65535;
      if (sim_alt < -8192) sim_alt = -8192;
      now = sim_now;
      alt = sim_alt[16:0];
   endtask

   task automatic run_flights(input int count, input int hold_off_at);
      logic [31:0]        now;
      logic signed [16:0] alt;
      for (int k = 0; k < count; k++) begin
         next_sample(now, alt);
         offer_pass(now, alt, 1'b0, '0);
         if (k == hold_off_at) hold_off_req = 400;
      end
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_now_ms = '0;
      req_altitude_ft = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      pin_next = 1'b0;
      pin_result = '0;
      errors = 0;
      idle_pct = 0;
      stall_pct = 0;
      hold_off_req = 0;
      seg_kind = SEG_GROUND;
      seg_left = 0;
      climb_thr = 300;
      jump_thr = -5000;
      band_fpm = 100;
      hold_ms = 60000;
      period_ms = 10000;
      phase_q = PHASE_WAIT;
      climb_q = 0;
      prev_alt = 0;
      last_rate_ms = '0;
      last_loop_ms = '0;
      first_sample = 1'b1;
      hold_left_ms = 0;
      hold_armed = 1'b0;

      // full cycle, then landed back to jumping and to flight, then time wrap
      script = '{
         '{32'd20000,      17'sd0,     1'b1, '{PHASE_WAIT, 1'b0, 21'sd0, 1'b1}},
         '{32'd20005,      17'sd5000,  1'b1, '{PHASE_WAIT, 1'b0, 21'sd0, 1'b0}},
         '{32'd30006,      17'sd5000,  1'b0, '0},
         '{32'd30010,      17'sd5000,  1'b0, '0},
         '{32'd40011,      17'sd13000, 1'b0, '0},
         '{32'd50012,      17'sd0,     1'b0, '0},
         '{32'd50013,      17'sd0,     1'b0, '0},
         '{32'd60014,      17'sd0,     1'b0, '0},
         '{32'd60015,      17'sd0,     1'b0, '0},
         '{32'd130000,     17'sd0,     1'b0, '0},
         '{32'd140001,     17'sd20000, 1'b0, '0},
         '{32'd140002,     17'sd20000, 1'b0, '0},
         '{32'd150003,     17'sd0,     1'b0, '0},
         '{32'd150004,     17'sd0,     1'b0, '0},
         '{32'd160005,     17'sd0,     1'b0, '0},
         '{32'd160006,     17'sd0,     1'b0, '0},
         '{32'd170007,     -17'sd8192, 1'b0, '0},
         '{32'd170008,     -17'sd8192, 1'b0, '0},
         '{32'd180009,     -17'sd8192, 1'b0, '0},
         '{32'd180010,     -17'sd8192, 1'b0, '0},
         '{32'd190011,     -17'sd8000, 1'b0, '0},
         '{32'd190012,     -17'sd8000, 1'b0, '0},
         '{32'hFFFF_FFFF,  17'sd65535, 1'b0, '0},
         '{32'd0,          17'sd65535, 1'b0, '0},
         '{32'd200013,     17'sd65535, 1'b0, '0}
      };

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (script[i]) begin
         offer_pass(script[i].now, script[i].alt, script[i].pinned, script[i].want);
         sim_now = script[i].now;
         sim_alt = script[i].alt;
      end
      run_flights(120, -1);

      configure(24'd0, 24'd0, 24'd0, 24'd0, 24'd1, 50, 0);
      run_flights(140, -1);

      configure(24'd65535, 24'h010001, 24'd65535, 24'hFFFFFF, 24'd65535, 0, 50);
      run_flights(140, -1);

      configure(24'd500, 24'h01F448, 24'd200, 24'd30000, 24'd0, 19, 19);
      run_flights(140, 20);

      // upper bits beyond each register's width are ignored
      configure(24'hFF03E8, 24'hFFE0C0, 24'd50, 24'd5000, 24'd2000, 0, 0);
      run_flights(140, -1);

      configure(24'($urandom()), 24'(-$urandom_range(20000)), 24'($urandom_range(400)),
                24'($urandom_range(100000)), 24'($urandom_range(20000)), 19, 19);
      run_flights(140, -1);

      settle();
      repeat (60) @(posedge clock);
      if (expected_passes.size() != 0) begin
         $error("%0d expected results never arrived", expected_passes.size());
         errors++;
      end
      if (errors == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

endmodule
